// ----- rtl/pidpi_pkg.sv -----
// Package for the PID controller: widths, register indexes, mode codes,
// configuration and stage-control structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pidpi_pkg;

	// Default sample width and fraction bits of gains and accumulators
	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 12;

	// Fixed register widths
	localparam int GAIN_W     = 24;
	localparam int LIM_W      = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] IDX_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_GAIN_P    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] IDX_GAIN_I    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_GAIN_D    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] IDX_OUT_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] IDX_INT_LIMIT = 3'd5;

	// Controller modes
	localparam logic MODE_POS = 1'b0;
	localparam logic MODE_INC = 1'b1;

	// Reset value of both limits
	localparam logic [LIM_W-1:0] LIMIT_RESET = 15'h7FFF;

	typedef struct packed {
		logic                     mode;
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [LIM_W-1:0]         out_limit;
		logic [LIM_W-1:0]         int_limit;
	} cfg_t;

	// en: the stage may load this cycle; valid: the stage upstream holds an item
	typedef struct packed {
		logic en;
		logic valid;
	} stage_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/pidpi_in_if.sv -----
// Sample channel: valid/ready handshake carrying setpoint and measured value.
// Depends on pidpi_pkg for the default width.
`timescale 1ns / 1ps
`default_nettype none

interface pidpi_in_if #(
	parameter int DW = pidpi_pkg::DATA_WIDTH_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] setpoint;
	logic signed [DW-1:0] measured;

	modport source (output valid, output setpoint, output measured, input ready);
	modport sink (input valid, input setpoint, input measured, output ready);
endinterface

`default_nettype wire

// ----- rtl/pidpi_out_if.sv -----
// Result channel: valid/ready handshake carrying drive and saturation flag.
// Depends on pidpi_pkg for the default width.
`timescale 1ns / 1ps
`default_nettype none

interface pidpi_out_if #(
	parameter int DW = pidpi_pkg::DATA_WIDTH_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] drive;
	logic                 out_saturated;

	modport source (output valid, output drive, output out_saturated, input ready);
	modport sink (input valid, input drive, input out_saturated, output ready);
endinterface

`default_nettype wire

// ----- rtl/pid_positional_incremental.sv -----
// Top level of the positional / incremental PID controller.
// Depends on pidpi_pkg, pidpi_in_if, pidpi_out_if, pidpi_cfg, pidpi_err,
// pidpi_mul and pidpi_acc.
//
//   port       direction  payload                       handshake
//   sample     in         setpoint, measured            valid / ready
//   result     out        drive, out_saturated          valid / ready
//   cfg_*      in         cfg_index, cfg_wdata          cfg_we, no back-pressure
//
// One transaction is accepted per clock unless the pipe is full behind a stalled result;
// four register stages (error, multiply, integral, output accumulator) carry it to the
// port. The integral and output accumulators each feed their own register back to their sum.
// Each stage loads whenever it is empty or the next stage moves, so a stalled
// result holds only its own register and bubbles behind it still fill.
// Reset clears the error history, accumulators and stage valids, and resets the configuration.
`timescale 1ns / 1ps
`default_nettype none

module pid_positional_incremental #(
	parameter int DATA_WIDTH = pidpi_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pidpi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pidpi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pidpi_pkg::CFG_DATA_W-1:0] cfg_wdata,
	pidpi_in_if.sink                              sample,
	pidpi_out_if.source                           result
);

	localparam int PW = pidpi_pkg::GAIN_W + DATA_WIDTH + 3;

	pidpi_pkg::cfg_t       cfg;
	pidpi_pkg::stage_ctl_t ctl_s1;
	pidpi_pkg::stage_ctl_t ctl_s2;
	pidpi_pkg::stage_ctl_t ctl_s3;
	pidpi_pkg::stage_ctl_t ctl_s4;

	logic                         valid_s1;
	logic                         valid_s2;
	logic                         valid_s3;
	logic                         valid_q;
	logic signed [DATA_WIDTH+1:0] op_p_s1;
	logic signed [DATA_WIDTH:0]   op_i_s1;
	logic signed [DATA_WIDTH+2:0] op_d_s1;
	logic signed [PW-1:0]         prod_p_s2;
	logic signed [PW-1:0]         prod_i_s2;
	logic signed [PW-1:0]         prod_d_s2;
	logic signed [DATA_WIDTH-1:0] drive_q;
	logic                         sat_q;

	// Stage enables: load when empty or when the next stage advances
	always_comb begin
		ctl_s4.en    = !valid_q || result.ready;
		ctl_s4.valid = valid_s3;
		ctl_s3.en    = !valid_s3 || ctl_s4.en;
		ctl_s3.valid = valid_s2;
		ctl_s2.en    = !valid_s2 || ctl_s3.en;
		ctl_s2.valid = valid_s1;
		ctl_s1.en    = !valid_s1 || ctl_s2.en;
		ctl_s1.valid = sample.valid;
	end

	assign sample.ready         = ctl_s1.en;
	assign result.valid         = valid_q;
	assign result.drive         = drive_q;
	assign result.out_saturated = sat_q;

	pidpi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pidpi_err #(.DW(DATA_WIDTH)) u_err (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_s1),
		.mode     (cfg.mode),
		.setpoint (sample.setpoint),
		.measured (sample.measured),
		.valid_s1 (valid_s1),
		.op_p_s1  (op_p_s1),
		.op_i_s1  (op_i_s1),
		.op_d_s1  (op_d_s1)
	);

	pidpi_mul #(.DW(DATA_WIDTH)) u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_s2),
		.cfg       (cfg),
		.op_p_s1   (op_p_s1),
		.op_i_s1   (op_i_s1),
		.op_d_s1   (op_d_s1),
		.valid_s2  (valid_s2),
		.prod_p_s2 (prod_p_s2),
		.prod_i_s2 (prod_i_s2),
		.prod_d_s2 (prod_d_s2)
	);

	pidpi_acc #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s3    (ctl_s3),
		.ctl_s4    (ctl_s4),
		.cfg       (cfg),
		.prod_p_s2 (prod_p_s2),
		.prod_i_s2 (prod_i_s2),
		.prod_d_s2 (prod_d_s2),
		.valid_s3  (valid_s3),
		.valid_q   (valid_q),
		.drive_q   (drive_q),
		.sat_q     (sat_q)
	);

endmodule

`default_nettype wire

// ----- rtl/pidpi_cfg.sv -----
// Configuration register file of the PID controller.
// Depends on pidpi_pkg (cfg_t, register indexes).
`timescale 1ns / 1ps
`default_nettype none

module pidpi_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [pidpi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pidpi_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output pidpi_pkg::cfg_t                          cfg
);

	pidpi_pkg::cfg_t cfg_q;

	// Decode the write index; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= pidpi_pkg::MODE_POS;
			cfg_q.gain_p    <= '0;
			cfg_q.gain_i    <= '0;
			cfg_q.gain_d    <= '0;
			cfg_q.out_limit <= pidpi_pkg::LIMIT_RESET;
			cfg_q.int_limit <= pidpi_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pidpi_pkg::IDX_MODE:      cfg_q.mode      <= cfg_wdata[0];
				pidpi_pkg::IDX_GAIN_P:    cfg_q.gain_p    <= $signed(cfg_wdata);
				pidpi_pkg::IDX_GAIN_I:    cfg_q.gain_i    <= $signed(cfg_wdata);
				pidpi_pkg::IDX_GAIN_D:    cfg_q.gain_d    <= $signed(cfg_wdata);
				pidpi_pkg::IDX_OUT_LIMIT: cfg_q.out_limit <= cfg_wdata[pidpi_pkg::LIM_W-1:0];
				pidpi_pkg::IDX_INT_LIMIT: cfg_q.int_limit <= cfg_wdata[pidpi_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/pidpi_err.sv -----
// Error stage: forms the error, its differences against the error history,
// and registers the multiplier operands. Depends on pidpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidpi_err #(
	parameter int DW = pidpi_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire pidpi_pkg::stage_ctl_t    ctl,
	input  wire logic                     mode,
	input  wire logic signed [DW-1:0]     setpoint,
	input  wire logic signed [DW-1:0]     measured,
	output logic                          valid_s1,
	output logic signed [DW+1:0]          op_p_s1,
	output logic signed [DW:0]            op_i_s1,
	output logic signed [DW+2:0]          op_d_s1
);

	localparam int EW  = DW + 1;
	localparam int D1W = DW + 2;
	localparam int D2W = DW + 3;

	logic signed [EW-1:0]  err;
	logic signed [D1W-1:0] diff1;
	logic signed [D2W-1:0] diff2;
	logic signed [EW-1:0]  err1_q;
	logic signed [EW-1:0]  err2_q;
	logic                  take;

	assign take = ctl.en && ctl.valid;

	// Error and its first and second differences
	always_comb begin
		err   = EW'(setpoint) - EW'(measured);
		diff1 = D1W'(err) - D1W'(err1_q);
		diff2 = D2W'(err) - (D2W'(err1_q) <<< 1) + D2W'(err2_q);
	end

	// Shift the error history on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err1_q <= '0;
			err2_q <= '0;
		end else if (take) begin
			err1_q <= err;
			err2_q <= err1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.en) begin
			valid_s1 <= ctl.valid;
		end
	end

	// Pick the operands of each gain by mode
	always_ff @(posedge clk) begin
		if (take) begin
			op_i_s1 <= err;
			op_p_s1 <= (mode == pidpi_pkg::MODE_INC) ? diff1 : D1W'(err);
			op_d_s1 <= (mode == pidpi_pkg::MODE_INC) ? diff2 : D2W'(diff1);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pidpi_mul.sv -----
// Multiplier stage: three gain products, registered.
// Depends on pidpi_pkg (cfg_t, gain width).
`timescale 1ns / 1ps
`default_nettype none

module pidpi_mul #(
	parameter int DW = pidpi_pkg::DATA_WIDTH_DEF,
	localparam int PW = pidpi_pkg::GAIN_W + DW + 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pidpi_pkg::stage_ctl_t ctl,
	input  wire pidpi_pkg::cfg_t       cfg,
	input  wire logic signed [DW+1:0]  op_p_s1,
	input  wire logic signed [DW:0]    op_i_s1,
	input  wire logic signed [DW+2:0]  op_d_s1,
	output logic                       valid_s2,
	output logic signed [PW-1:0]       prod_p_s2,
	output logic signed [PW-1:0]       prod_i_s2,
	output logic signed [PW-1:0]       prod_d_s2
);

	logic signed [PW-1:0] mul_p;
	logic signed [PW-1:0] mul_i;
	logic signed [PW-1:0] mul_d;

	// Products are exact in PW bits
	always_comb begin
		mul_p = PW'(cfg.gain_p) * PW'(op_p_s1);
		mul_i = PW'(cfg.gain_i) * PW'(op_i_s1);
		mul_d = PW'(cfg.gain_d) * PW'(op_d_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.en) begin
			valid_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && ctl.valid) begin
			prod_p_s2 <= mul_p;
			prod_i_s2 <= mul_i;
			prod_d_s2 <= mul_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pidpi_acc.sv -----
// Accumulator stages: integral clamp and sum, then output accumulator,
// output clamp, truncation and result register. Depends on pidpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidpi_acc #(
	parameter int DW = pidpi_pkg::DATA_WIDTH_DEF,
	parameter int FB = pidpi_pkg::FRAC_BITS_DEF,
	localparam int PW = pidpi_pkg::GAIN_W + DW + 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pidpi_pkg::stage_ctl_t ctl_s3,
	input  wire pidpi_pkg::stage_ctl_t ctl_s4,
	input  wire pidpi_pkg::cfg_t       cfg,
	input  wire logic signed [PW-1:0]  prod_p_s2,
	input  wire logic signed [PW-1:0]  prod_i_s2,
	input  wire logic signed [PW-1:0]  prod_d_s2,
	output logic                       valid_s3,
	output logic                       valid_q,
	output logic signed [DW-1:0]       drive_q,
	output logic                       sat_q
);

	localparam int LW = pidpi_pkg::LIM_W;
	localparam int AW = LW + FB + 1;
	localparam int SW = PW + 3;
	localparam int CW = (DW - 1 > LW) ? DW - 1 : LW;
	localparam logic [CW-1:0] DMAX = CW'((64'd1 << (DW - 1)) - 64'd1);
	localparam logic [AW:0]   RND  = (AW + 1)'((64'd1 << FB) - 64'd1);

	logic signed [AW-1:0] ilim;
	logic signed [AW-1:0] olim;
	logic [CW-1:0]        olim_w;
	logic [LW-1:0]        olim_int;
	logic signed [SW-1:0] isum;
	logic signed [SW-1:0] pi_w;
	logic signed [AW-1:0] integ_pos;
	logic signed [AW-1:0] integ_inc;
	logic signed [AW-1:0] integ_nx;
	logic signed [AW-1:0] integ_q;
	logic signed [SW-1:0] sum_nx;
	logic signed [SW-1:0] sum_s3;
	logic signed [SW-1:0] acc;
	logic signed [AW-1:0] acc_clamp;
	logic                 acc_sat;
	logic signed [AW:0]   acc_adj;
	logic signed [AW-1:0] out_acc_q;

	// Limits in accumulator format; the drive bound also fits the drive field
	always_comb begin
		olim_w   = CW'(cfg.out_limit);
		olim_int = LW'((olim_w > DMAX) ? DMAX : olim_w);
		ilim     = {1'b0, cfg.int_limit, {FB{1'b0}}};
		olim     = {1'b0, olim_int, {FB{1'b0}}};
	end

	// Integral term: accumulate and clamp, or clamp the new term alone
	always_comb begin
		pi_w = SW'(prod_i_s2);
		isum = SW'(integ_q) + pi_w;
		if (isum > SW'(ilim)) begin
			integ_pos = ilim;
		end else if (isum < -SW'(ilim)) begin
			integ_pos = -ilim;
		end else begin
			integ_pos = AW'(isum);
		end
		if (pi_w > SW'(ilim)) begin
			integ_inc = ilim;
		end else if (pi_w < -SW'(ilim)) begin
			integ_inc = -ilim;
		end else begin
			integ_inc = AW'(pi_w);
		end
		integ_nx = (cfg.mode == pidpi_pkg::MODE_INC) ? integ_inc : integ_pos;
		sum_nx   = SW'(prod_p_s2) + SW'(prod_d_s2) + SW'(integ_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q  <= '0;
			valid_s3 <= 1'b0;
		end else if (ctl_s3.en) begin
			valid_s3 <= ctl_s3.valid;
			if (ctl_s3.valid) begin
				integ_q <= integ_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s3.en && ctl_s3.valid) begin
			sum_s3 <= sum_nx;
		end
	end

	// Output accumulator: add the previous drive in incremental mode, then clamp
	always_comb begin
		acc = sum_s3 + ((cfg.mode == pidpi_pkg::MODE_INC) ? SW'(out_acc_q) : '0);
		acc_sat = 1'b0;
		if (acc > SW'(olim)) begin
			acc_clamp = olim;
			acc_sat   = 1'b1;
		end else if (acc < -SW'(olim)) begin
			acc_clamp = -olim;
			acc_sat   = 1'b1;
		end else begin
			acc_clamp = AW'(acc);
		end
		// Truncate toward zero: bias negative values before the shift
		acc_adj = (AW + 1)'(acc_clamp) + (acc_clamp[AW-1] ? RND : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_acc_q <= '0;
			valid_q   <= 1'b0;
		end else if (ctl_s4.en) begin
			valid_q <= ctl_s4.valid;
			if (ctl_s4.valid) begin
				out_acc_q <= acc_clamp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s4.en && ctl_s4.valid) begin
			drive_q <= DW'(acc_adj >>> FB);
			sat_q   <= acc_sat;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pidpi_chk.sv -----
// Port-level checker for the PID controller, bound to the top level.
// Depends on pidpi_pkg (register index, limit width and reset value).
`timescale 1ns / 1ps
`default_nettype none

module pidpi_chk #(
	parameter int DW = pidpi_pkg::DATA_WIDTH_DEF
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             cfg_we,
	input wire logic [pidpi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input wire logic [pidpi_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic signed [DW-1:0]             drive,
	input wire logic                             out_saturated
);

	localparam int LW = pidpi_pkg::LIM_W;
	localparam int CW = (DW - 1 > LW) ? DW - 1 : LW;
	localparam logic [CW-1:0] DMAX = CW'((64'd1 << (DW - 1)) - 64'd1);

	logic [LW-1:0]      olim_q;
	logic [CW-1:0]      olim_w;
	logic signed [DW:0] lim;
	logic signed [DW:0] drive_w;

	// Shadow the output limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			olim_q <= pidpi_pkg::LIMIT_RESET;
		end else if (cfg_we && cfg_index == pidpi_pkg::IDX_OUT_LIMIT) begin
			olim_q <= cfg_wdata[LW-1:0];
		end
	end

	always_comb begin
		olim_w  = CW'(olim_q);
		lim     = (DW + 1)'((olim_w > DMAX) ? DMAX : olim_w);
		drive_w = (DW + 1)'(drive);
	end

	// A stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(out_saturated))
		else $error("result changed while stalled");

	// Input back-pressure only comes from a full pipe behind a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("sample not ready without a stalled result");

	// A saturated drive sits exactly on the effective bound
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_saturated |-> drive_w == lim || drive_w == -lim)
		else $error("saturated drive off the bound");

	// Every drive stays within the effective bound
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_w <= lim && drive_w >= -lim)
		else $error("drive outside the bound");

endmodule

bind pid_positional_incremental pidpi_chk #(.DW(DATA_WIDTH)) u_pidpi_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.cfg_index     (cfg_index),
	.cfg_wdata     (cfg_wdata),
	.in_ready      (sample.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.drive         (result.drive),
	.out_saturated (result.out_saturated)
);

`default_nettype wire

// ----- test/pidpi_drive_checker.sv -----
// Checker for the PID controller: watches the register port and both channels,
// predicts each drive value and its saturation flag, and compares them in order.
// Depends on pidpi_pkg, pidpi_in_if and pidpi_out_if.
`timescale 1ns / 1ps

module pidpi_drive_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pidpi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pidpi_pkg::CFG_DATA_W-1:0] cfg_wdata,
	pidpi_in_if                              sample,
	pidpi_out_if                             result,
	output int unsigned                      fails,
	output int unsigned                      pending,
	output int unsigned                      checked,
	output int unsigned                      saturated
);
	import pidpi_pkg::*;

	localparam int     DW         = DATA_WIDTH_DEF;
	localparam int     FRAC       = FRAC_BITS_DEF;
	localparam longint DRIVE_MAX  = (64'sd1 <<< (DW - 1)) - 1;
	localparam int     REPORT_MAX = 10;

	typedef struct packed {
		logic signed [DW-1:0] drive;
		logic                 out_saturated;
	} drive_t;

	cfg_t                 ctl;
	logic signed [DW:0]   err_hist1;
	logic signed [DW:0]   err_hist2;
	longint               integ;
	longint               out_acc;
	drive_t               drive_due[$];

	function automatic longint clip(input longint x, input longint lim);
		if (x > lim)
			return lim;
		if (x < -lim)
			return -lim;
		return x;
	endfunction

	// Advance the controller state by one sample and return its drive value
	function automatic drive_t next_drive(input logic signed [DW-1:0] sp,
			input logic signed [DW-1:0] mv);
		longint err, e1, e2, gp, gi, gd, ilim, olim, acc, iterm;
		drive_t r;
		err  = longint'(sp) - longint'(mv);
		e1   = longint'(err_hist1);
		e2   = longint'(err_hist2);
		gp   = longint'($signed(ctl.gain_p));
		gi   = longint'($signed(ctl.gain_i));
		gd   = longint'($signed(ctl.gain_d));
		ilim = longint'(ctl.int_limit) <<< FRAC;
		olim = longint'(ctl.out_limit);
		if (olim > DRIVE_MAX)
			olim = DRIVE_MAX;
		olim = olim <<< FRAC;
		if (ctl.mode == MODE_POS) begin
			integ = clip(integ + gi * err, ilim);
			acc   = gp * err + integ + gd * (err - e1);
		end else begin
			// the clamped integral term of this sample also becomes the integral
			iterm = clip(gi * err, ilim);
			integ = iterm;
			acc   = out_acc + gp * (err - e1) + iterm + gd * (err - 2 * e1 + e2);
		end
		// a value exactly on the bound is not flagged
		r.out_saturated = (acc > olim) || (acc < -olim);
		acc       = clip(acc, olim);
		out_acc   = acc;
		err_hist2 = err_hist1;
		err_hist1 = err[DW:0];
		r.drive   = DW'(acc / (64'sd1 <<< FRAC));
		return r;
	endfunction

	task automatic note_fail(input string what);
		fails++;
		if (fails <= REPORT_MAX)
			$display("%0t ns: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_t want;
		if (!arst_n) begin
			ctl.mode      = MODE_POS;
			ctl.gain_p    = '0;
			ctl.gain_i    = '0;
			ctl.gain_d    = '0;
			ctl.out_limit = LIMIT_RESET;
			ctl.int_limit = LIMIT_RESET;
			err_hist1     = '0;
			err_hist2     = '0;
			integ         = 0;
			out_acc       = 0;
			drive_due.delete();
		end else begin
			// track register writes; unknown indexes change nothing
			if (cfg_we) begin
				case (cfg_index)
					IDX_MODE:      ctl.mode = cfg_wdata[0];
					IDX_GAIN_P:    ctl.gain_p = cfg_wdata[GAIN_W-1:0];
					IDX_GAIN_I:    ctl.gain_i = cfg_wdata[GAIN_W-1:0];
					IDX_GAIN_D:    ctl.gain_d = cfg_wdata[GAIN_W-1:0];
					IDX_OUT_LIMIT: ctl.out_limit = cfg_wdata[LIM_W-1:0];
					IDX_INT_LIMIT: ctl.int_limit = cfg_wdata[LIM_W-1:0];
					default: ;
				endcase
			end
			// predict on every accepted sample transaction
			if (sample.valid && sample.ready)
				drive_due.push_back(next_drive(sample.setpoint, sample.measured));
			// compare each accepted result transaction with the oldest prediction
			if (result.valid && result.ready) begin
				if (drive_due.size() == 0) begin
					note_fail($sformatf("result with none due: drive %0d sat %0b",
						result.drive, result.out_saturated));
				end else begin
					want = drive_due.pop_front();
					checked++;
					if (want.out_saturated)
						saturated++;
					if (result.drive !== want.drive ||
							result.out_saturated !== want.out_saturated)
						note_fail($sformatf("drive %0d sat %0b, expected drive %0d sat %0b",
							result.drive, result.out_saturated,
							want.drive, want.out_saturated));
				end
			end
		end
		pending = drive_due.size();
	end

	initial begin
		fails     = 0;
		pending   = 0;
		checked   = 0;
		saturated = 0;
	end

endmodule

// ----- test/pid_positional_incremental_tb.sv -----
// Top of the PID controller testbench: clock, reset, register writes and
// sample stimulus with random idling; the drive checker judges every result.
// Depends on pidpi_pkg, both channel interfaces, the block and pidpi_drive_checker.
`timescale 1ns / 1ps

module pid_positional_incremental_tb;
	import pidpi_pkg::*;

	localparam int      DW              = DATA_WIDTH_DEF;
	localparam longint  CYCLE_LIMIT     = 400000;
	localparam int      HOLD_CYCLES     = 48;
	localparam int      SETTLE_CYCLES   = 8;
	localparam int      PHASES_PER_SPELL = 4;
	localparam int      ITEMS_PER_PHASE = 95;
	localparam int      TRACK_SPAN      = 200;
	localparam logic [CFG_DATA_W-1:0] GAIN_MAX = 24'h7FFFFF;
	localparam logic [CFG_DATA_W-1:0] GAIN_MIN = 24'h800000;
	localparam logic [CFG_DATA_W-1:0] GAIN_ONE = 24'd4096;
	localparam logic [CFG_IDX_W-1:0]  IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0]  IDX_SPARE_HI = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int unsigned           fails, pending, checked, saturated;
	int unsigned           send_idle = 0;
	int unsigned           recv_idle = 0;
	int unsigned           hold_left = 0;
	int unsigned           sent = 0;
	int unsigned           settings = 0;
	int                    track_sp = 0;
	longint unsigned       cycles = 0;

	pidpi_in_if  sample_ch ();
	pidpi_out_if result_ch ();

	pid_positional_incremental uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	pidpi_drive_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_ch),
		.result    (result_ch),
		.fails     (fails),
		.pending   (pending),
		.checked   (checked),
		.saturated (saturated)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// abandon a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result receiver: random stalls, or a long hold-off when asked
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				result_ch.ready = 1'b0;
				hold_left--;
			end else begin
				result_ch.ready = ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_setting(input logic [CFG_DATA_W-1:0] mode_w, gp, gi, gd,
			olim, ilim);
		write_reg(IDX_MODE, mode_w);
		write_reg(IDX_GAIN_P, gp);
		write_reg(IDX_GAIN_I, gi);
		write_reg(IDX_GAIN_D, gd);
		write_reg(IDX_OUT_LIMIT, olim);
		write_reg(IDX_INT_LIMIT, ilim);
		settings++;
	endtask

	// offer one sample transaction, with random idle cycles ahead of it
	task automatic push_sample(input int sp, input int mv);
		while ($urandom_range(0, 99) < send_idle) begin
			sample_ch.valid = 1'b0;
			@(negedge clk);
		end
		sample_ch.valid    = 1'b1;
		sample_ch.setpoint = sp[DW-1:0];
		sample_ch.measured = mv[DW-1:0];
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// drop valid and hold until every predicted drive has come back
	task automatic wait_results();
		sample_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_gain();
		case ($urandom_range(0, 9))
			0:       return GAIN_MAX;
			1:       return GAIN_MIN;
			2:       return '0;
			3:       return CFG_DATA_W'($urandom());
			default: return CFG_DATA_W'(int'($urandom_range(0, 16384)) - 8192);
		endcase
	endfunction

	// limit word with junk above the limit field
	function automatic logic [CFG_DATA_W-1:0] rand_limit();
		logic [LIM_W-1:0] lim;
		case ($urandom_range(0, 7))
			0:       lim = '0;
			1:       lim = LIMIT_RESET;
			2, 3:    lim = LIM_W'($urandom_range(1, 200));
			default: lim = LIM_W'($urandom_range(0, 32767));
		endcase
		return {(CFG_DATA_W - LIM_W)'($urandom()), lim};
	endfunction

	// mostly a loop tracking a setpoint with small errors, sometimes full-range noise
	task automatic push_random();
		int sp, mv;
		if ($urandom_range(0, 9) < 3) begin
			sp = int'($urandom_range(0, 65535)) - 32768;
			mv = int'($urandom_range(0, 65535)) - 32768;
		end else begin
			if ($urandom_range(0, 15) == 0)
				track_sp = int'($urandom_range(0, 65535)) - 32768;
			sp = track_sp;
			mv = track_sp + int'($urandom_range(0, 2 * TRACK_SPAN)) - TRACK_SPAN;
			if (mv > 32767)
				mv = 32767;
			if (mv < -32768)
				mv = -32768;
		end
		push_sample(sp, mv);
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		sample_ch.valid    = 1'b0;
		sample_ch.setpoint = '0;
		sample_ch.measured = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: all gains zero, extreme errors give zero drive
		push_sample(32767, -32768);
		push_sample(-32768, 32767);
		push_sample(0, 0);

		// pure proportional drive landing on, just inside and just past the bound
		wait_results();
		load_setting(CFG_DATA_W'(MODE_POS), GAIN_ONE, '0, '0, 24'd100, 24'd32767);
		push_sample(100, 0);
		push_sample(0, 100);
		push_sample(101, 0);
		push_sample(0, 101);
		push_sample(99, 0);

		// extreme gains with a zero integral limit
		wait_results();
		load_setting(CFG_DATA_W'(MODE_POS), GAIN_MAX, GAIN_MIN, GAIN_MAX, 24'd32767, '0);
		push_sample(32767, -32768);
		push_sample(-32768, 32767);
		push_sample(1, 0);
		push_sample(0, 0);

		// zero output limit in incremental mode
		wait_results();
		load_setting(CFG_DATA_W'(MODE_INC), GAIN_ONE, GAIN_ONE, GAIN_ONE, '0, 24'd50);
		push_sample(10, 0);
		push_sample(-5, 3);
		push_sample(32767, -32768);

		// incremental run, then switch to positional on the same history
		wait_results();
		load_setting(CFG_DATA_W'(MODE_INC), 24'd2048, 24'd300, CFG_DATA_W'(-1024),
			24'd32767, 24'd1000);
		push_sample(100, 20);
		push_sample(50, 60);
		push_sample(-200, 0);
		push_sample(7, 7);
		wait_results();
		write_reg(IDX_MODE, CFG_DATA_W'(MODE_POS));
		write_reg(IDX_SPARE_LO, 24'hFFFFFF);
		write_reg(IDX_SPARE_HI, 24'h5A5A5A);
		push_sample(30, 10);
		push_sample(-30, 10);

		// random phases under three idling regimes
		for (int spell = 0; spell < 3; spell++) begin
			case (spell)
				0: begin
					send_idle = 32;
					recv_idle = 60;
				end
				1: begin
					send_idle = 60;
					recv_idle = 32;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int ph = 0; ph < PHASES_PER_SPELL; ph++) begin
				wait_results();
				load_setting({(CFG_DATA_W - 1)'($urandom()),
						(ph % 2 == 0) ? MODE_POS : MODE_INC},
					rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit());
				if ($urandom_range(0, 3) == 0)
					write_reg($urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO,
						CFG_DATA_W'($urandom()));
				// fill the pipeline against a stalled receiver
				if (spell == 2 && ph == 0)
					hold_left = HOLD_CYCLES;
				for (int n = 0; n < ITEMS_PER_PHASE; n++)
					push_random();
			end
		end

		wait_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Ran %0d samples over %0d register settings in both modes, with idling",
			sent, settings);
		$display("on each side and a full-pipeline stall; %0d drives checked, %0d clamped.",
			checked, saturated);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
